>>> rtl/pdst_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and arithmetic helpers for the PPS sample time-tagging block.
package pdst_pkg;

  // Event codes on the input word
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_PPS  = 2'd1;
  localparam logic [1:0] FUNC_ADC  = 2'd2;
  localparam logic [1:0] FUNC_NMEA = 2'd3;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_DECIM   = 2'd0;
  localparam logic [1:0] REG_LOCK_TO = 2'd1;
  localparam logic [1:0] REG_PERIOD  = 2'd2;

  // Result word kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_PPS    = 1'b1;

  localparam int CNT_W = 32;
  localparam int UTC_W = 25;
  localparam int OFS_W = 16;

  localparam logic [3:0]  DECIM_RST   = 4'd5;
  localparam logic [15:0] LOCK_TO_RST = 16'd3000;
  localparam logic [15:0] PERIOD_RST  = 16'd1000;

  // Clock arithmetic in base-100 digits
  localparam logic [6:0] RADIX      = 7'd100;
  localparam logic [6:0] SEC_PER_MN = 7'd60;
  localparam logic [6:0] MN_PER_HR  = 7'd60;
  localparam logic [5:0] HR_PER_DAY = 6'd24;

  // 2^25 written as hh|mm|ss|cc digits; a bumped value at or above it wraps
  localparam logic [5:0] WRAP_HH = 6'd33;
  localparam logic [6:0] WRAP_MM = 7'd55;
  localparam logic [6:0] WRAP_SS = 7'd44;
  localparam logic [6:0] WRAP_CC = 7'd32;

  // UTC held as decimal digit pairs
  typedef struct packed {
    logic [5:0] hh;
    logic [6:0] mm;
    logic [6:0] ss;
    logic [6:0] cc;
  } utc_dig_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

  // floor(n / 100) for n below 2^25, by reciprocal multiply
  function automatic logic [18:0] div100(input logic [24:0] n);
    logic [55:0] p;
    p = 56'(n) * 56'd1374389535;
    return p[55:37];
  endfunction

  function automatic logic [UTC_W-1:0] utc_to_bin(input utc_dig_t d);
    logic [UTC_W-1:0] acc;
    acc = UTC_W'(d.hh) * UTC_W'(1000000) + UTC_W'(d.mm) * UTC_W'(10000)
        + UTC_W'(d.ss) * UTC_W'(100) + UTC_W'(d.cc);
    return acc;
  endfunction

endpackage

>>> rtl/pdst_rem_unit.sv
`timescale 1ns / 1ps
// Bit-serial remainder unit: rebuilds the sample offset modulo the PPS period.
module pdst_rem_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [31:0]           dividend,
  input  logic [15:0]           divisor,
  output pdst_pkg::rem_stat_t   stat,
  output logic [15:0]           rem
);

  localparam logic [5:0] STEPS = 6'(pdst_pkg::CNT_W);

  logic [5:0]  cnt_r;
  logic [31:0] dvd_r;
  logic [15:0] rem_r;
  logic        done_r;
  logic [16:0] trial;
  logic [15:0] rem_nxt;

  // one quotient bit a cycle, restoring form
  always_comb begin
    trial = {rem_r, dvd_r[31]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = 16'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = trial[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= STEPS;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 6'd1;
      done_r <= (cnt_r == 6'd1);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign stat = '{busy: (cnt_r != '0), done: done_r};
  assign rem  = rem_r;

endmodule

>>> rtl/pdst_sec_step.sv
`timescale 1ns / 1ps
// One-second UTC advance in digit form, with carries, day wrap and 25-bit wrap.
module pdst_sec_step (
  input  pdst_pkg::utc_dig_t cur,
  output pdst_pkg::utc_dig_t nxt
);

  logic [6:0] ss1, mm1, ss2, mm2, mm3, sw, mw;
  logic [5:0] hh1, hh3, hw, hinc;
  logic       wrap, bs, bm;

  always_comb begin
    hinc = cur.hh + 6'd1;
    ss1  = cur.ss + 7'd1;
    mm1  = cur.mm;
    hh1  = cur.hh;
    // carry only when seconds hit sixty exactly
    if (ss1 == pdst_pkg::SEC_PER_MN) begin
      ss1 = '0;
      mm1 = cur.mm + 7'd1;
      if (mm1 == pdst_pkg::MN_PER_HR) begin
        mm1 = '0;
        hh1 = (hinc >= pdst_pkg::HR_PER_DAY) ? hinc - pdst_pkg::HR_PER_DAY : hinc;
      end
    end

    // malformed digits can reach one hundred: fold into the next pair
    if (ss1 == pdst_pkg::RADIX) begin
      ss2 = '0;
      mm2 = mm1 + 7'd1;
    end else begin
      ss2 = ss1;
      mm2 = mm1;
    end
    if (mm2 == pdst_pkg::RADIX) begin
      mm3 = '0;
      hh3 = hh1 + 6'd1;
    end else begin
      mm3 = mm2;
      hh3 = hh1;
    end

    wrap = (hh3 > pdst_pkg::WRAP_HH)
        || ((hh3 == pdst_pkg::WRAP_HH)
            && ((mm3 > pdst_pkg::WRAP_MM)
                || ((mm3 == pdst_pkg::WRAP_MM) && (ss2 > pdst_pkg::WRAP_SS))));

    // subtract 2^25 digit pair by digit pair; the cc pair always borrows
    bs = (ss2 < pdst_pkg::WRAP_SS + 7'd1);
    if (bs) begin
      sw = ss2 + pdst_pkg::RADIX - pdst_pkg::WRAP_SS - 7'd1;
    end else begin
      sw = ss2 - pdst_pkg::WRAP_SS - 7'd1;
    end
    bm = (mm3 < pdst_pkg::WRAP_MM + 7'(bs));
    if (bm) begin
      mw = mm3 + pdst_pkg::RADIX - pdst_pkg::WRAP_MM - 7'(bs);
    end else begin
      mw = mm3 - pdst_pkg::WRAP_MM - 7'(bs);
    end
    hw = hh3 - pdst_pkg::WRAP_HH - 6'(bm);

    if (wrap) begin
      nxt.hh = hw;
      nxt.mm = mw;
      nxt.ss = sw;
      nxt.cc = pdst_pkg::RADIX - pdst_pkg::WRAP_CC;
    end else begin
      nxt.hh = hh3;
      nxt.mm = mm3;
      nxt.ss = ss2;
      nxt.cc = '0;
    end
  end

endmodule

>>> rtl/pps_disciplined_sample_timetag.sv
`timescale 1ns / 1ps
// Top level of the PPS-disciplined sample time-tagging block.
// A result word passes through input stages v1_r to v4_r and the result register.
// Throughput: one input word per cycle; the pipeline holds while out_stall backs it up
// or the remainder unit is busy. After a write to pps_period_ms the input stalls while
// the serial remainder unit rebuilds the sample offset, one bit per cycle.
// Synchronous active-low reset clears the block state and loads the register defaults.
module pps_disciplined_sample_timetag (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [24:0] in_nmea_time,
  input  logic        in_fix_fresh,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_kind,
  output logic [24:0] out_utc_stamp,
  output logic [15:0] out_offset_ms,
  output logic [31:0] out_counter_ms,
  output logic        out_is_locked,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [3:0]  decim_r;
  logic [15:0] lock_to_r;
  logic [15:0] period_r;
  logic [15:0] period_eff;
  logic        wr_en;
  logic [1:0]  reg_idx;
  logic        start_r;

  // input pipeline: digit split of the NMEA time
  logic        v1_r, v2_r, v3_r, v4_r;
  logic [1:0]  f1_r, f2_r, f3_r, f4_r;
  logic        fr1_r, fr2_r, fr3_r, fr4_r;
  logic [24:0] n1_r;
  logic [18:0] q2_r, q3_r;
  logic [11:0] t3_r, t4_r;
  logic [5:0]  hh4_r;
  logic [6:0]  ss4_r;
  logic [18:0] t3_full, hh4_full;
  logic [6:0]  mm4;

  // block state
  logic [31:0] ms_r, ms_nxt;
  logic [31:0] d_r, d_nxt;
  logic [15:0] rofs_r, rofs_nxt;
  logic        pend_r, pend_nxt;
  logic        uvalid_r, uvalid_nxt;
  logic [31:0] last_r, last_nxt;
  logic        locked_r, locked_nxt;
  logic [3:0]  dcnt_r, dcnt_nxt;
  pdst_pkg::utc_dig_t utc_r, utc_nxt, utc_bump, utc_nmea;

  logic [31:0] ms_inc, age, d_inc;
  logic [15:0] r_inc;
  logic [32:0] sum33;
  logic [3:0]  dc_inc;

  // result
  logic        emit;
  logic        kind_nxt;
  logic [15:0] ofs_nxt;
  logic        out_valid_r;
  logic        kind_r;
  pdst_pkg::utc_dig_t utc_out_r;
  logic [15:0] ofs_r;
  logic [31:0] cnt_out_r;
  logic        lck_out_r;

  pdst_pkg::rem_stat_t rstat;
  logic [15:0] rem_val;
  logic        busy, hold, adv;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_r   <= pdst_pkg::DECIM_RST;
      lock_to_r <= pdst_pkg::LOCK_TO_RST;
      period_r  <= pdst_pkg::PERIOD_RST;
      start_r   <= 1'b0;
    end else begin
      start_r <= wr_en && (reg_idx == pdst_pkg::REG_PERIOD);
      if (wr_en) begin
        case (reg_idx)
          pdst_pkg::REG_DECIM:   decim_r   <= pwdata[3:0];
          pdst_pkg::REG_LOCK_TO: lock_to_r <= pwdata[15:0];
          pdst_pkg::REG_PERIOD:  period_r  <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      pdst_pkg::REG_DECIM:   prdata = {28'd0, decim_r};
      pdst_pkg::REG_LOCK_TO: prdata = {16'd0, lock_to_r};
      pdst_pkg::REG_PERIOD:  prdata = {16'd0, period_r};
      default:               prdata = '0;
    endcase
  end

  assign period_eff = (period_r == '0) ? 16'd1 : period_r;

  // ---------------- flow control ----------------
  assign busy     = start_r | rstat.busy | rstat.done;
  assign hold     = busy | (out_valid_r & out_stall);
  assign adv      = ~hold;
  assign in_stall = hold;

  pdst_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (d_r),
    .divisor  (period_eff),
    .stat     (rstat),
    .rem      (rem_val)
  );

  // ---------------- input pipeline ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign t3_full  = pdst_pkg::div100(25'(q2_r));
  assign hh4_full = pdst_pkg::div100(25'(t3_r));

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r  <= in_func;
      fr1_r <= in_fix_fresh;
      n1_r  <= in_nmea_time;
      f2_r  <= f1_r;
      fr2_r <= fr1_r;
      q2_r  <= pdst_pkg::div100(n1_r);
      f3_r  <= f2_r;
      fr3_r <= fr2_r;
      q3_r  <= q2_r;
      t3_r  <= t3_full[11:0];
      f4_r  <= f3_r;
      fr4_r <= fr3_r;
      t4_r  <= t3_r;
      hh4_r <= hh4_full[5:0];
      ss4_r <= 7'(q3_r - 19'(t3_r) * 19'd100);
    end
  end

  assign mm4 = 7'(t4_r - 12'(hh4_r) * 12'd100);

  always_comb begin
    utc_nmea.hh = hh4_r;
    utc_nmea.mm = mm4;
    utc_nmea.ss = ss4_r;
    utc_nmea.cc = '0;
  end

  pdst_sec_step u_step (
    .cur (utc_r),
    .nxt (utc_bump)
  );

  // ---------------- event processing ----------------
  assign ms_inc = ms_r + 32'd1;
  assign age    = ms_inc - last_r;
  assign d_inc  = d_r + 32'd1;
  assign r_inc  = rofs_r + 16'd1;
  assign sum33  = {1'b0, d_r} + {17'd0, period_eff};
  assign dc_inc = dcnt_r + 4'd1;

  always_comb begin
    ms_nxt     = ms_r;
    d_nxt      = d_r;
    rofs_nxt   = rofs_r;
    pend_nxt   = pend_r;
    uvalid_nxt = uvalid_r;
    last_nxt   = last_r;
    locked_nxt = locked_r;
    dcnt_nxt   = dcnt_r;
    utc_nxt    = utc_r;
    emit       = 1'b0;
    kind_nxt   = pdst_pkg::KIND_SAMPLE;
    ofs_nxt    = '0;
    if (v4_r) begin
      case (f4_r)
        pdst_pkg::FUNC_TICK: begin
          ms_nxt = ms_inc;
          d_nxt  = d_inc;
          // track (counter - capture) mod period incrementally
          if (d_inc == '0) begin
            rofs_nxt = '0;
          end else begin
            rofs_nxt = (r_inc == period_eff) ? 16'd0 : r_inc;
          end
          if (age > 32'(lock_to_r)) begin
            locked_nxt = 1'b0;
          end
        end
        pdst_pkg::FUNC_PPS: begin
          d_nxt    = '0;
          rofs_nxt = '0;
          pend_nxt = 1'b1;
          if (locked_r && uvalid_r) begin
            utc_nxt = utc_bump;
          end
          emit     = 1'b1;
          kind_nxt = pdst_pkg::KIND_PPS;
        end
        pdst_pkg::FUNC_ADC: begin
          if (dc_inc < decim_r) begin
            dcnt_nxt = dc_inc;
          end else begin
            dcnt_nxt = '0;
            emit     = 1'b1;
            // difference plus period overflowing: the low word is the offset
            ofs_nxt  = sum33[32] ? sum33[15:0] : rofs_r;
          end
        end
        pdst_pkg::FUNC_NMEA: begin
          utc_nxt    = utc_nmea;
          uvalid_nxt = 1'b1;
          last_nxt   = ms_r;
          if (fr4_r && pend_r) begin
            locked_nxt = 1'b1;
            pend_nxt   = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r     <= '0;
      d_r      <= '0;
      rofs_r   <= '0;
      pend_r   <= 1'b0;
      uvalid_r <= 1'b0;
      last_r   <= '0;
      locked_r <= 1'b0;
      dcnt_r   <= '0;
      utc_r    <= '0;
    end else if (rstat.done) begin
      rofs_r <= rem_val;
    end else if (adv) begin
      ms_r     <= ms_nxt;
      d_r      <= d_nxt;
      rofs_r   <= rofs_nxt;
      pend_r   <= pend_nxt;
      uvalid_r <= uvalid_nxt;
      last_r   <= last_nxt;
      locked_r <= locked_nxt;
      dcnt_r   <= dcnt_nxt;
      utc_r    <= utc_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      kind_r    <= kind_nxt;
      utc_out_r <= utc_nxt;
      ofs_r     <= ofs_nxt;
      cnt_out_r <= ms_r;
      lck_out_r <= locked_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_record_kind = kind_r;
  assign out_utc_stamp   = pdst_pkg::utc_to_bin(utc_out_r);
  assign out_offset_ms   = ofs_r;
  assign out_counter_ms  = cnt_out_r;
  assign out_is_locked   = lck_out_r;

endmodule

>>> rtl/pdst_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the time-tagging block, bound to the top level.
module pdst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_record_kind,
  input logic [15:0] out_offset_ms,
  input logic [31:0] out_counter_ms
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // a PPS tag always carries zero offset
  a_pps_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_record_kind == pdst_pkg::KIND_PPS)) |-> (out_offset_ms == 16'd0))
    else $error("PPS tag with nonzero offset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_counter_ms) && $stable(out_offset_ms)
                                  && $stable(out_record_kind)))
    else $error("stalled result word changed");

endmodule

bind pps_disciplined_sample_timetag pdst_checker u_pdst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_record_kind (out_record_kind),
  .out_offset_ms   (out_offset_ms),
  .out_counter_ms  (out_counter_ms)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the PPS-disciplined sample time-tagging block.
module testbench;

  typedef struct packed {
    logic        kind;
    logic [24:0] utc;
    logic [15:0] ofs;
    logic [31:0] cnt;
    logic        lock;
  } tag_t;

  typedef struct {
    logic [1:0]  f;
    logic [24:0] t;
    logic        fr;
    bit          typed;
    tag_t        want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = pdst_pkg::FUNC_TICK;
  logic [24:0] in_nmea_time = '0;
  logic        in_fix_fresh = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_record_kind;
  logic [24:0] out_utc_stamp;
  logic [15:0] out_offset_ms;
  logic [31:0] out_counter_ms;
  logic        out_is_locked;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pps_disciplined_sample_timetag dut (.*);

  always #1 clk = ~clk;

  // Timing state mirrored from the block
  logic [3:0]  cfg_decim  = pdst_pkg::DECIM_RST;
  logic [15:0] cfg_lock   = pdst_pkg::LOCK_TO_RST;
  logic [15:0] cfg_period = pdst_pkg::PERIOD_RST;
  logic [31:0] ms_cnt = '0;
  logic [31:0] pps_cap = '0;
  logic [31:0] last_fix_ms = '0;
  logic [24:0] utc_reg = '0;
  logic        pps_pend = 1'b0;
  logic        utc_ok = 1'b0;
  logic        lock_st = 1'b0;
  logic [3:0]  decim_cnt = '0;

  tag_t        pending_tags[$];
  script_row_t script[$];

  int  errors = 0;
  int  n_words = 0;
  int  n_checked = 0;
  int  n_pps = 0;
  int  n_sample = 0;
  int  n_lock = 0;
  int  n_unlock = 0;
  bit  quiet = 1'b0;
  bit  tx_gappy = 1'b1;
  int  rx_left = 0;
  bit  rx_stalling = 1'b0;

  function automatic logic [24:0] utc_plus_second(input logic [24:0] t);
    int unsigned tv, hh, mm, ss, v;
    tv = 32'(t);
    hh = (tv / 1000000) % 100;
    mm = (tv / 10000) % 100;
    ss = (tv / 100) % 100;
    ss++;
    // carry only on an exact 60; malformed digits just keep counting
    if (ss == 60) begin
      ss = 0;
      mm++;
      if (mm == 60) begin
        mm = 0;
        hh = (hh + 1) % 24;
      end
    end
    v = hh * 1000000 + mm * 10000 + ss * 100;
    return v[24:0];
  endfunction

  function automatic void tag_event(input logic [1:0] f, input logic [24:0] t, input logic fr,
                                    output bit got, output tag_t r);
    logic [31:0] span;
    logic [31:0] per;
    got = 1'b0;
    r = '0;
    case (f)
      pdst_pkg::FUNC_TICK: begin
        ms_cnt++;
        span = ms_cnt - last_fix_ms;
        if (span > {16'd0, cfg_lock}) begin
          if (lock_st) n_unlock++;
          lock_st = 1'b0;
        end
      end
      pdst_pkg::FUNC_PPS: begin
        pps_cap = ms_cnt;
        pps_pend = 1'b1;
        if (lock_st && utc_ok) utc_reg = utc_plus_second(utc_reg);
        got = 1'b1;
        r = '{pdst_pkg::KIND_PPS, utc_reg, 16'd0, ms_cnt, lock_st};
      end
      pdst_pkg::FUNC_ADC: begin
        decim_cnt++;
        if (decim_cnt >= cfg_decim) begin
          decim_cnt = '0;
          per = (cfg_period == 16'd0) ? 32'd1 : {16'd0, cfg_period};
          span = ms_cnt - pps_cap + per;
          got = 1'b1;
          r = '{pdst_pkg::KIND_SAMPLE, utc_reg, 16'(span % per), ms_cnt, lock_st};
        end
      end
      pdst_pkg::FUNC_NMEA: begin
        utc_reg = 25'((32'(t) / 100) * 100);
        utc_ok = 1'b1;
        last_fix_ms = ms_cnt;
        if (fr && pps_pend) begin
          if (!lock_st) n_lock++;
          lock_st = 1'b1;
          pps_pend = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void add_row(input logic [1:0] f, input logic [24:0] t, input logic fr);
    script_row_t row;
    row.f = f;
    row.t = t;
    row.fr = fr;
    row.typed = 1'b0;
    row.want = '0;
    script.push_back(row);
  endfunction

  function automatic void add_typed(input logic [1:0] f, input logic k, input logic [24:0] u,
                                    input logic [15:0] o, input logic [31:0] c, input logic l);
    script_row_t row;
    row.f = f;
    row.t = '0;
    row.fr = 1'b0;
    row.typed = 1'b1;
    row.want = '{k, u, o, c, l};
    script.push_back(row);
  endfunction

  function automatic logic [24:0] pick_nmea();
    int unsigned r, hh, mm, ss, cc;
    r = $urandom_range(0, 9);
    if (r < 2) return 25'($urandom);
    hh = (r == 2) ? 23 : $urandom_range(0, 23);
    mm = (r < 4) ? 59 : $urandom_range(0, 59);
    ss = (r < 6) ? 59 : $urandom_range(0, 59);
    cc = $urandom_range(0, 99);
    return 25'(hh * 1000000 + mm * 10000 + ss * 100 + cc);
  endfunction

  task automatic send_word(input logic [1:0] f, input logic [24:0] t, input logic fr,
                           input bit typed = 1'b0, input tag_t want = '0);
    bit   got;
    tag_t tag;
    if (!quiet && tx_gappy && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_nmea_time <= t;
    in_fix_fresh <= fr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_words++;
    tag_event(f, t, fr, got, tag);
    if (got) pending_tags.push_back(typed ? want : tag);
  endtask

  task automatic send_random();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) send_word(pdst_pkg::FUNC_TICK, 25'($urandom), 1'($urandom));
    else if (p < 70) send_word(pdst_pkg::FUNC_ADC, 25'($urandom), 1'($urandom));
    else if (p < 80) send_word(pdst_pkg::FUNC_PPS, 25'($urandom), 1'($urandom));
    else send_word(pdst_pkg::FUNC_NMEA, pick_nmea(), $urandom_range(0, 3) != 0);
  endtask

  // Hold off input until every expected word is back, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] held;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      pdst_pkg::REG_DECIM:   cfg_decim = val[3:0];
      pdst_pkg::REG_LOCK_TO: cfg_lock = val[15:0];
      pdst_pkg::REG_PERIOD:  cfg_period = val[15:0];
      default: ;
    endcase
    held = (idx == pdst_pkg::REG_DECIM) ? {28'd0, cfg_decim} :
           (idx == pdst_pkg::REG_LOCK_TO) ? {16'd0, cfg_lock} : {16'd0, cfg_period};
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("prdata", held, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] d, input logic [31:0] l, input logic [31:0] p);
    write_reg(pdst_pkg::REG_DECIM, d);
    write_reg(pdst_pkg::REG_LOCK_TO, l);
    write_reg(pdst_pkg::REG_PERIOD, p);
  endtask

  always @(posedge clk) begin : rx_pace
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      rx_left = 0;
    end else begin
      if (rx_left == 0) begin
        rx_stalling = ($urandom_range(0, 2) == 0);
        rx_left = rx_stalling ? $urandom_range(1, 13) : $urandom_range(1, 40);
      end
      rx_left--;
      out_stall <= rx_stalling;
    end
  end

  always @(posedge clk) begin : tag_monitor
    tag_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tags.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, utc %0d counter %0d", $time,
                 out_utc_stamp, out_counter_ms);
      end else begin
        want = pending_tags.pop_front();
        n_checked++;
        if (want.kind == pdst_pkg::KIND_PPS) n_pps++;
        else n_sample++;
        check_field("record_kind", 32'(want.kind), 32'(out_record_kind));
        check_field("utc_stamp", 32'(want.utc), 32'(out_utc_stamp));
        check_field("offset_ms", 32'(want.ofs), 32'(out_offset_ms));
        check_field("counter_ms", want.cnt, out_counter_ms);
        check_field("is_locked", 32'(want.lock), 32'(out_is_locked));
      end
    end
  end

  initial begin
    #1_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    // reset-state tags, lock on a day wrap, a malformed time, minute and odd-second carries
    add_typed(pdst_pkg::FUNC_PPS, pdst_pkg::KIND_PPS, 25'd0, 16'd0, 32'd0, 1'b0);
    repeat (4) add_row(pdst_pkg::FUNC_ADC, 25'd0, 1'b0);
    add_typed(pdst_pkg::FUNC_ADC, pdst_pkg::KIND_SAMPLE, 25'd0, 16'd0, 32'd0, 1'b0);
    repeat (3) add_row(pdst_pkg::FUNC_TICK, 25'h1FFFFFF, 1'b1);
    add_row(pdst_pkg::FUNC_NMEA, 25'd23595999, 1'b1);
    add_typed(pdst_pkg::FUNC_PPS, pdst_pkg::KIND_PPS, 25'd0, 16'd0, 32'd3, 1'b1);
    add_row(pdst_pkg::FUNC_NMEA, 25'h1FFFFFF, 1'b0);
    add_row(pdst_pkg::FUNC_PPS, 25'd0, 1'b0);
    add_row(pdst_pkg::FUNC_NMEA, 25'd12345678, 1'b1);
    add_row(pdst_pkg::FUNC_NMEA, 25'd0, 1'b1);
    repeat (5) add_row(pdst_pkg::FUNC_ADC, 25'd0, 1'b0);
    add_row(pdst_pkg::FUNC_NMEA, 25'd595912, 1'b1);
    add_row(pdst_pkg::FUNC_PPS, 25'd0, 1'b0);
    add_row(pdst_pkg::FUNC_NMEA, 25'd9999, 1'b1);
    add_row(pdst_pkg::FUNC_PPS, 25'd0, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send_word(script[i].f, script[i].t, script[i].fr, script[i].typed,
                                  script[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: set_regs(32'd1, 32'd1, 32'd1);
          2: set_regs(32'd0, 32'd65535, 32'd0);
          3: set_regs(32'd15, 32'd2, 32'd65535);
          4: set_regs($urandom_range(0, 15), $urandom_range(1, 40), $urandom_range(1, 2000));
          default: set_regs(32'd3, 32'd3000, 32'd1000);
        endcase
      end
      if (ph == 5) quiet = 1'b1;
      for (int i = 0; i < 288; i++) begin
        if (i % 40 == 0) tx_gappy = ($urandom_range(0, 2) != 0);
        if (ph == 0 && i == 150) wait_idle();
        send_random();
      end
    end
    wait_idle();

    $display("testbench: %0d input words, %0d result words checked (%0d PPS, %0d sample)",
             n_words, n_checked, n_pps, n_sample);
    $display("testbench: lock gained %0d times and lost %0d times over six register settings",
             n_lock, n_unlock);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
